### rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PMS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pms property violated");

// condition must never be seen outside reset
`define PMS_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("pms forbidden condition seen");

`endif

### rtl/pms_pkg.sv
package pms_pkg;

  localparam int unsigned MAX_OBSTACLES = 16;

  // configuration register indexes
  localparam logic [2:0] CFG_TIME_STEP    = 3'd0;
  localparam logic [2:0] CFG_MASS         = 3'd1;
  localparam logic [2:0] CFG_DAMPING      = 3'd2;
  localparam logic [2:0] CFG_WORLD_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_WORLD_HEIGHT = 3'd4;
  localparam logic [2:0] CFG_SLOTS        = 3'd5;

  // register reset values
  localparam logic [16:0] RST_TIME_STEP = 17'd3277;
  localparam logic [30:0] RST_MASS      = 31'd65536;
  localparam logic [30:0] RST_DAMPING   = 31'd65536;
  localparam logic [13:0] RST_WORLD     = 14'd100;
  localparam logic [4:0]  RST_SLOTS     = 5'd0;

  localparam logic [32:0] HALF_UNIT = 33'd32768;
  localparam logic signed [31:0] DEADZONE = 32'sd7;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_MUL_DAMP,
    OP_DIV_ACC,
    OP_TAKE_A,
    OP_MUL_ADT,
    OP_UPD_V,
    OP_MUL_VDT,
    OP_UPD_P,
    OP_RD,
    OP_GEOM,
    OP_ZERO,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQRT,
    OP_DIST,
    OP_HIT,
    OP_NX,
    OP_NY,
    OP_MUL_NXOV,
    OP_UPD_X,
    OP_UPD_Y,
    OP_VD1,
    OP_VD2,
    OP_VX,
    OP_VX2,
    OP_VY2,
    OP_DONE
  } pms_op_e;

  typedef struct packed {
    pms_op_e op;
    logic    comp;   // 0 = x component, 1 = y component
  } pms_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic slot_end;
    logic active;
    logic zero_off;
    logic far;
    logic no_ovl;
    logic vdot_neg;
  } pms_stat_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic fits;
    fits = (v[67:31] == {37{v[67]}});
    if (fits) begin
      sat32 = v[31:0];
    end else if (v[67]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

### rtl/pms_div.sv
// restoring divider, one quotient bit per cycle
module pms_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [63:0] quotient_o,
  output logic        done_o
);

  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] dvs_q;
  logic [5:0]  cnt_q;
  logic        run_q;
  logic        done_q;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // trial subtraction
  assign trial = {rem_q, quo_q[63]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

### rtl/pms_sqrt.sv
// digit-by-digit integer square root, one root bit per cycle
module pms_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic [31:0] root_o,
  output logic        done_o
);

  logic [63:0] rad_q;
  logic [31:0] root_q;
  logic [33:0] rem_q;
  logic [4:0]  cnt_q;
  logic        run_q;
  logic        done_q;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [35:0] diff;

  // bring down two bits and try the next root bit
  assign rem_sh = {rem_q, rad_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= ge ? diff[33:0] : rem_sh[33:0];
      root_q <= {root_q[30:0], ge};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

### rtl/pms_dp.sv
// datapath: drone state, registers, obstacle table, multiplier, divider, root
module pms_dp #(
  parameter int unsigned MAX_OBSTACLES = pms_pkg::MAX_OBSTACLES,
  parameter int unsigned SW = $clog2(MAX_OBSTACLES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pms_pkg::pms_cmd_t   cmd_i,
  input  logic [SW-1:0]       slot_i,
  output pms_pkg::pms_stat_t  st_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic signed [31:0]  force_x_i,
  input  logic signed [31:0]  force_y_i,
  input  logic                reset_request_i,
  input  logic [3:0]          obstacle_index_i,
  input  logic signed [31:0]  obstacle_pos_x_i,
  input  logic signed [31:0]  obstacle_pos_y_i,
  input  logic [30:0]         obstacle_radius_i,
  input  logic                obstacle_active_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  vel_x_o,
  output logic signed [31:0]  vel_y_o,
  output logic                collided_o,
  output logic                done_o
);

  localparam int unsigned IW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

  // configuration
  logic [16:0] time_step_q;
  logic [30:0] mass_q;
  logic [30:0] damping_q;
  logic [13:0] world_w_q;
  logic [13:0] world_h_q;
  logic [4:0]  slots_q;

  // drone state
  logic signed [31:0] x_q, y_q, vx_q, vy_q;
  logic hit_q, done_q;

  // obstacle table
  logic signed [31:0] ox_mem [MAX_OBSTACLES];
  logic signed [31:0] oy_mem [MAX_OBSTACLES];
  logic [30:0]        or_mem [MAX_OBSTACLES];
  logic [MAX_OBSTACLES-1:0] act_q;
  logic signed [31:0] ox_rd_q, oy_rd_q;
  logic [30:0]        or_rd_q;
  logic               act_rd_q;

  // working registers
  logic signed [31:0] fx_q, fy_q;
  logic signed [67:0] prod_q, acc_q;
  logic               div_neg_q;
  logic signed [31:0] a_q;
  logic signed [32:0] dx_q, dy_q;
  logic [32:0]        min_q;
  logic [31:0]        dist_q;
  logic [32:0]        ov_q;
  logic signed [17:0] nx_q, ny_q;
  logic signed [33:0] vdot_q;

  // combinational helpers
  pms_pkg::pms_op_e   op;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_d;
  logic signed [67:0] prod_sh;
  logic signed [31:0] f_sel, v_sel, p_sel;
  logic signed [67:0] num;
  logic [63:0]        num_mag;
  logic [32:0]        absdx, absdy;
  logic [8:0]         ld_idx_w;
  logic [IW-1:0]      ld_idx;
  logic               ld_ok;
  logic [IW-1:0]      rd_idx;
  logic [8:0]         lim;
  logic               div_start;
  logic [63:0]        div_dvd;
  logic [31:0]        div_dvs;
  logic [63:0]        quot;
  logic               div_done;
  logic [31:0]        root;
  logic               sqrt_done;
  logic signed [31:0] v_new, v_sat;
  logic signed [67:0] p_sum;
  logic signed [67:0] p_hi;
  logic signed [31:0] p_new;
  logic signed [31:0] a_new;
  logic [31:0]        world_sel;

  assign op = cmd_i.op;

  // component selection
  assign f_sel     = cmd_i.comp ? fy_q : fx_q;
  assign v_sel     = cmd_i.comp ? vy_q : vx_q;
  assign p_sel     = cmd_i.comp ? y_q : x_q;
  assign world_sel = cmd_i.comp ? {18'd0, world_h_q} : {18'd0, world_w_q};

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      pms_pkg::OP_MUL_DAMP: begin
        mul_a = $signed({3'b000, damping_q});
        mul_b = 34'(v_sel);
      end
      pms_pkg::OP_MUL_ADT: begin
        mul_a = 34'(a_q);
        mul_b = $signed({17'd0, time_step_q});
      end
      pms_pkg::OP_MUL_VDT: begin
        mul_a = 34'(v_sel);
        mul_b = $signed({17'd0, time_step_q});
      end
      pms_pkg::OP_SQ_X: begin
        mul_a = 34'(dx_q);
        mul_b = 34'(dx_q);
      end
      pms_pkg::OP_SQ_Y: begin
        mul_a = 34'(dy_q);
        mul_b = 34'(dy_q);
      end
      pms_pkg::OP_MUL_NXOV: begin
        mul_a = 34'(nx_q);
        mul_b = $signed({1'b0, ov_q});
      end
      pms_pkg::OP_UPD_X: begin
        mul_a = 34'(ny_q);
        mul_b = $signed({1'b0, ov_q});
      end
      pms_pkg::OP_UPD_Y: begin
        mul_a = 34'(vx_q);
        mul_b = 34'(nx_q);
      end
      pms_pkg::OP_VD1: begin
        mul_a = 34'(vy_q);
        mul_b = 34'(ny_q);
      end
      pms_pkg::OP_VX: begin
        mul_a = vdot_q;
        mul_b = 34'(nx_q);
      end
      pms_pkg::OP_VX2: begin
        mul_a = vdot_q;
        mul_b = 34'(ny_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d  = mul_a * mul_b;
  assign prod_sh = prod_q >>> 16;

  // acceleration numerator
  assign num     = (68'(f_sel) <<< 16) - prod_q;
  assign num_mag = num[67] ? 64'(-num) : 64'(num);

  // acceleration from quotient with saturation
  always_comb begin
    if (div_neg_q) begin
      a_new = (quot > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : -$signed(quot[31:0]);
    end else begin
      a_new = (quot > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quot[31:0]);
    end
  end

  // velocity update with deadzone
  assign v_sat = pms_pkg::sat32(68'(v_sel) + prod_sh);
  assign v_new = (v_sat > -pms_pkg::DEADZONE && v_sat < pms_pkg::DEADZONE) ? '0 : v_sat;

  // position update clamped to the world
  assign p_sum = 68'(p_sel) + prod_sh;
  assign p_hi  = $signed({36'd0, world_sel}) <<< 16;
  always_comb begin
    if (p_sum[67]) begin
      p_new = '0;
    end else if (p_sum > p_hi) begin
      p_new = p_hi[31:0];
    end else begin
      p_new = p_sum[31:0];
    end
  end

  // offset magnitudes
  assign absdx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign absdy = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_dvd   = num_mag;
    div_dvs   = (mass_q == '0) ? 32'd1 : {1'b0, mass_q};
    case (op)
      pms_pkg::OP_DIV_ACC: begin
        div_start = 1'b1;
      end
      pms_pkg::OP_HIT: begin
        div_start = 1'b1;
        div_dvd   = {15'd0, absdx, 16'd0};
        div_dvs   = dist_q;
      end
      pms_pkg::OP_NX: begin
        div_start = 1'b1;
        div_dvd   = {15'd0, absdy, 16'd0};
        div_dvs   = dist_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (quot),
    .done_o     (div_done)
  );

  pms_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (op == pms_pkg::OP_SQRT),
    .radicand_i (64'(acc_q + prod_q)),
    .root_o     (root),
    .done_o     (sqrt_done)
  );

  // table addressing
  assign ld_idx_w = 9'(obstacle_index_i);
  assign ld_idx   = ld_idx_w[IW-1:0];
  assign ld_ok    = ld_idx_w < 9'(MAX_OBSTACLES);
  assign rd_idx   = slot_i[IW-1:0];
  assign lim      = (9'(slots_q) > 9'(MAX_OBSTACLES)) ? 9'(MAX_OBSTACLES) : 9'(slots_q);

  // table storage
  always_ff @(posedge clk_i) begin
    if (op == pms_pkg::OP_LOAD && ld_ok) begin
      ox_mem[ld_idx] <= obstacle_pos_x_i;
      oy_mem[ld_idx] <= obstacle_pos_y_i;
      or_mem[ld_idx] <= obstacle_radius_i;
    end
    if (op == pms_pkg::OP_RD) begin
      ox_rd_q <= ox_mem[rd_idx];
      oy_rd_q <= oy_mem[rd_idx];
      or_rd_q <= or_mem[rd_idx];
    end
  end

  // active flags, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= '0;
      act_rd_q <= 1'b0;
    end else begin
      if (op == pms_pkg::OP_LOAD && ld_ok) begin
        act_q[ld_idx] <= obstacle_active_i;
      end
      if (op == pms_pkg::OP_RD) begin
        act_rd_q <= act_q[rd_idx];
      end
    end
  end

  // configuration, drone state and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= pms_pkg::RST_TIME_STEP;
      mass_q      <= pms_pkg::RST_MASS;
      damping_q   <= pms_pkg::RST_DAMPING;
      world_w_q   <= pms_pkg::RST_WORLD;
      world_h_q   <= pms_pkg::RST_WORLD;
      slots_q     <= pms_pkg::RST_SLOTS;
      x_q         <= $signed({3'd0, pms_pkg::RST_WORLD, 15'd0});
      y_q         <= $signed({3'd0, pms_pkg::RST_WORLD, 15'd0});
      vx_q        <= '0;
      vy_q        <= '0;
      hit_q       <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      done_q <= (op == pms_pkg::OP_DONE);
      if (cfg_we_i) begin
        case (cfg_index_i)
          pms_pkg::CFG_TIME_STEP:    time_step_q <= cfg_data_i[16:0];
          pms_pkg::CFG_MASS:         mass_q      <= cfg_data_i[30:0];
          pms_pkg::CFG_DAMPING:      damping_q   <= cfg_data_i[30:0];
          pms_pkg::CFG_WORLD_WIDTH:  world_w_q   <= cfg_data_i[13:0];
          pms_pkg::CFG_WORLD_HEIGHT: world_h_q   <= cfg_data_i[13:0];
          pms_pkg::CFG_SLOTS:        slots_q     <= cfg_data_i[4:0];
          default: begin
          end
        endcase
      end
      case (op)
        pms_pkg::OP_START: begin
          hit_q <= 1'b0;
          if (reset_request_i) begin
            x_q  <= $signed({3'd0, world_w_q, 15'd0});
            y_q  <= $signed({3'd0, world_h_q, 15'd0});
            vx_q <= '0;
            vy_q <= '0;
          end
        end
        pms_pkg::OP_UPD_V: begin
          if (cmd_i.comp) vy_q <= v_new;
          else vx_q <= v_new;
        end
        pms_pkg::OP_UPD_P: begin
          if (cmd_i.comp) y_q <= p_new;
          else x_q <= p_new;
        end
        pms_pkg::OP_ZERO: begin
          x_q  <= pms_pkg::sat32(68'(x_q) + $signed({35'd0, min_q}));
          vx_q <= '0;
          vy_q <= '0;
        end
        pms_pkg::OP_HIT: begin
          hit_q <= 1'b1;
        end
        pms_pkg::OP_UPD_X: begin
          x_q <= pms_pkg::sat32(68'(x_q) + prod_sh);
        end
        pms_pkg::OP_UPD_Y: begin
          y_q <= pms_pkg::sat32(68'(y_q) + prod_sh);
        end
        pms_pkg::OP_VX2: begin
          vx_q <= pms_pkg::sat32(68'(vx_q) - prod_sh);
        end
        pms_pkg::OP_VY2: begin
          vy_q <= pms_pkg::sat32(68'(vy_q) - prod_sh);
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (op)
      pms_pkg::OP_START: begin
        fx_q <= force_x_i;
        fy_q <= force_y_i;
      end
      pms_pkg::OP_DIV_ACC: div_neg_q <= num[67];
      pms_pkg::OP_TAKE_A:  a_q <= a_new;
      pms_pkg::OP_GEOM: begin
        dx_q  <= 33'(x_q) - 33'(ox_rd_q);
        dy_q  <= 33'(y_q) - 33'(oy_rd_q);
        min_q <= {2'b00, or_rd_q} + pms_pkg::HALF_UNIT;
      end
      pms_pkg::OP_SQ_Y:  acc_q <= prod_q;
      pms_pkg::OP_DIST:  dist_q <= root;
      pms_pkg::OP_HIT:   ov_q <= min_q - {1'b0, dist_q};
      pms_pkg::OP_NX:    nx_q <= dx_q[32] ? -$signed(quot[17:0]) : $signed(quot[17:0]);
      pms_pkg::OP_NY:    ny_q <= dy_q[32] ? -$signed(quot[17:0]) : $signed(quot[17:0]);
      pms_pkg::OP_VD1:   acc_q <= prod_q;
      pms_pkg::OP_VD2:   vdot_q <= 34'((acc_q + prod_q) >>> 16);
      default: begin
      end
    endcase
  end

  // status back to the controller
  always_comb begin
    st_o.div_done  = div_done;
    st_o.sqrt_done = sqrt_done;
    st_o.slot_end  = 9'(slot_i) >= lim;
    st_o.active    = act_rd_q;
    st_o.zero_off  = (dx_q == '0) && (dy_q == '0);
    st_o.far       = (absdx >= min_q) || (absdy >= min_q);
    st_o.no_ovl    = {1'b0, dist_q} >= min_q;
    st_o.vdot_neg  = vdot_q[33];
  end

  assign pos_x_o    = x_q;
  assign pos_y_o    = y_q;
  assign vel_x_o    = vx_q;
  assign vel_y_o    = vy_q;
  assign collided_o = hit_q;
  assign done_o     = done_q;

endmodule

### rtl/pms_ctrl.sv
`include "assert_macros.svh"

// sequencer for obstacle loads from idle and for one tick: velocity, position, then the obstacle walk
module pms_ctrl #(
  parameter int unsigned MAX_OBSTACLES = pms_pkg::MAX_OBSTACLES,
  parameter int unsigned SW = $clog2(MAX_OBSTACLES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               command_i,
  output logic               busy_o,
  output pms_pkg::pms_cmd_t  cmd_o,
  output logic [SW-1:0]      slot_o,
  input  pms_pkg::pms_stat_t st_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_VMUL, S_VDIV, S_VWAIT, S_VMULA, S_VUPD,
    S_PMUL, S_PUPD,
    S_SCHK, S_SACT, S_STEST, S_SQY, S_SQRT, S_SWAIT, S_DTEST,
    S_NXW, S_NYW, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
    S_OUT
  } state_e;

  state_e        state_q, state_d;
  logic          comp_q, comp_d;
  logic [SW-1:0] slot_q, slot_d;

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    comp_d     = comp_q;
    slot_d     = slot_q;
    cmd_o.op   = pms_pkg::OP_NONE;
    cmd_o.comp = comp_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (command_i) begin
            cmd_o.op = pms_pkg::OP_LOAD;
          end else begin
            cmd_o.op = pms_pkg::OP_START;
            comp_d   = 1'b0;
            state_d  = S_VMUL;
          end
        end
      end
      S_VMUL: begin
        cmd_o.op = pms_pkg::OP_MUL_DAMP;
        state_d  = S_VDIV;
      end
      S_VDIV: begin
        cmd_o.op = pms_pkg::OP_DIV_ACC;
        state_d  = S_VWAIT;
      end
      S_VWAIT: begin
        if (st_i.div_done) begin
          cmd_o.op = pms_pkg::OP_TAKE_A;
          state_d  = S_VMULA;
        end
      end
      S_VMULA: begin
        cmd_o.op = pms_pkg::OP_MUL_ADT;
        state_d  = S_VUPD;
      end
      S_VUPD: begin
        cmd_o.op = pms_pkg::OP_UPD_V;
        comp_d   = ~comp_q;
        state_d  = comp_q ? S_PMUL : S_VMUL;
      end
      S_PMUL: begin
        cmd_o.op = pms_pkg::OP_MUL_VDT;
        state_d  = S_PUPD;
      end
      S_PUPD: begin
        cmd_o.op = pms_pkg::OP_UPD_P;
        comp_d   = ~comp_q;
        slot_d   = '0;
        state_d  = comp_q ? S_SCHK : S_PMUL;
      end
      // obstacle walk
      S_SCHK: begin
        if (st_i.slot_end) begin
          state_d = S_OUT;
        end else begin
          cmd_o.op = pms_pkg::OP_RD;
          state_d  = S_SACT;
        end
      end
      S_SACT: begin
        if (st_i.active) begin
          cmd_o.op = pms_pkg::OP_GEOM;
          state_d  = S_STEST;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_SCHK;
        end
      end
      S_STEST: begin
        if (st_i.zero_off) begin
          cmd_o.op = pms_pkg::OP_ZERO;
          slot_d   = slot_q + 1'b1;
          state_d  = S_SCHK;
        end else if (st_i.far) begin
          slot_d  = slot_q + 1'b1;
          state_d = S_SCHK;
        end else begin
          cmd_o.op = pms_pkg::OP_SQ_X;
          state_d  = S_SQY;
        end
      end
      S_SQY: begin
        cmd_o.op = pms_pkg::OP_SQ_Y;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = pms_pkg::OP_SQRT;
        state_d  = S_SWAIT;
      end
      S_SWAIT: begin
        if (st_i.sqrt_done) begin
          cmd_o.op = pms_pkg::OP_DIST;
          state_d  = S_DTEST;
        end
      end
      S_DTEST: begin
        if (st_i.no_ovl) begin
          slot_d  = slot_q + 1'b1;
          state_d = S_SCHK;
        end else begin
          cmd_o.op = pms_pkg::OP_HIT;
          state_d  = S_NXW;
        end
      end
      S_NXW: begin
        if (st_i.div_done) begin
          cmd_o.op = pms_pkg::OP_NX;
          state_d  = S_NYW;
        end
      end
      S_NYW: begin
        if (st_i.div_done) begin
          cmd_o.op = pms_pkg::OP_NY;
          state_d  = S_M1;
        end
      end
      S_M1: begin
        cmd_o.op = pms_pkg::OP_MUL_NXOV;
        state_d  = S_M2;
      end
      S_M2: begin
        cmd_o.op = pms_pkg::OP_UPD_X;
        state_d  = S_M3;
      end
      S_M3: begin
        cmd_o.op = pms_pkg::OP_UPD_Y;
        state_d  = S_M4;
      end
      S_M4: begin
        cmd_o.op = pms_pkg::OP_VD1;
        state_d  = S_M5;
      end
      S_M5: begin
        cmd_o.op = pms_pkg::OP_VD2;
        state_d  = S_M6;
      end
      S_M6: begin
        if (st_i.vdot_neg) begin
          cmd_o.op = pms_pkg::OP_VX;
          state_d  = S_M7;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_SCHK;
        end
      end
      S_M7: begin
        cmd_o.op = pms_pkg::OP_VX2;
        state_d  = S_M8;
      end
      S_M8: begin
        cmd_o.op = pms_pkg::OP_VY2;
        slot_d   = slot_q + 1'b1;
        state_d  = S_SCHK;
      end
      S_OUT: begin
        cmd_o.op = pms_pkg::OP_DONE;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      comp_q  <= 1'b0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      comp_q  <= comp_d;
      slot_q  <= slot_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign slot_o = slot_q;

  `PMS_ASSERT(a_tick_goes_busy, clk_i, rst_ni, (start_i && !busy_o && !command_i) |=> busy_o)
  `PMS_ASSERT(a_load_stays_idle, clk_i, rst_ni, (start_i && !busy_o && command_i) |=> !busy_o)
  `PMS_NEVER(a_take_needs_quotient, clk_i, rst_ni,
    (cmd_o.op == pms_pkg::OP_TAKE_A || cmd_o.op == pms_pkg::OP_NY) && !st_i.div_done)
  `PMS_NEVER(a_slot_in_range, clk_i, rst_ni, 32'(slot_q) > MAX_OBSTACLES)

endmodule

### rtl/point_mass_step_with_circle_collisions_top.sv
// channel  | direction | handshake                 | payload
// command  | in        | start_i, taken when !busy | command, forces, reset request, obstacle
// result   | out       | done_o, one-cycle strobe  | pos_x/y, vel_x/y, collided
// config   | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// an obstacle load completes in the accepting cycle; busy_o stays low
// a tick keeps busy_o high, strobing done_o as busy_o falls; the time per slot grows from
// inactive to far or zero offset to no overlap to overlap; the 64-step divider (twice per
// tick, twice per overlap) and the 32-step square root (once per distance test) run within it
// rst_ni clears configuration, drone state and control registers to their reset values and marks every slot inactive
// results cannot be held off; the strobe lasts exactly one cycle
module point_mass_step_with_circle_collisions_top #(
  parameter int unsigned MAX_OBSTACLES = pms_pkg::MAX_OBSTACLES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               command_i,
  input  logic signed [31:0] force_x_i,
  input  logic signed [31:0] force_y_i,
  input  logic               reset_request_i,
  input  logic [3:0]         obstacle_index_i,
  input  logic signed [31:0] obstacle_pos_x_i,
  input  logic signed [31:0] obstacle_pos_y_i,
  input  logic [30:0]        obstacle_radius_i,
  input  logic               obstacle_active_i,
  output logic               done_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic               collided_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned SW = $clog2(MAX_OBSTACLES + 1);

  pms_pkg::pms_cmd_t  cmd;
  pms_pkg::pms_stat_t st;
  logic [SW-1:0]      slot;

  // registers are always ready for a transfer
  assign cfg_ready_o = 1'b1;

  pms_ctrl #(
    .MAX_OBSTACLES (MAX_OBSTACLES),
    .SW            (SW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .busy_o    (busy_o),
    .cmd_o     (cmd),
    .slot_o    (slot),
    .st_i      (st)
  );

  pms_dp #(
    .MAX_OBSTACLES (MAX_OBSTACLES),
    .SW            (SW)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .slot_i            (slot),
    .st_o              (st),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .force_x_i         (force_x_i),
    .force_y_i         (force_y_i),
    .reset_request_i   (reset_request_i),
    .obstacle_index_i  (obstacle_index_i),
    .obstacle_pos_x_i  (obstacle_pos_x_i),
    .obstacle_pos_y_i  (obstacle_pos_y_i),
    .obstacle_radius_i (obstacle_radius_i),
    .obstacle_active_i (obstacle_active_i),
    .pos_x_o           (pos_x_o),
    .pos_y_o           (pos_y_o),
    .vel_x_o           (vel_x_o),
    .vel_y_o           (vel_y_o),
    .collided_o        (collided_o),
    .done_o            (done_o)
  );

endmodule
